@@ rtl/pte_pkg.sv @@
// Shared types and constants for the process table keyed store.
// Holds the table depth, command and status codes, the slot record layout
// and the update bundle that the sequencer hands to the top level.
package pte_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [RANK_W-1:0] rank_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [4:0]        ecount_t;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DELETE  = 2'd1,
    CMD_LOOKUP  = 2'd2,
    CMD_SETPRIO = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIX,
    S_FINISH
  } state_t;

  // One table entry as it sits in the slot memory.
  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
    logic [15:0] mem;
    rank_t       rank;
  } slot_t;

  // Result of one command plus the change it makes to the valid bits.
  typedef struct packed {
    logic        fin;
    logic        set_en;
    logic        clr_en;
    idx_t        slot;
    status_t     status;
    logic [7:0]  fprio;
    logic [15:0] fmem;
  } upd_t;

endpackage

@@ rtl/process_table_keyed_store.sv @@
// Process table keyed store, top level: valid bits, live count and result register.
// A command accepted while idle scans every slot, takes a second pass for a delete that hits,
// then commits in a finish state; the result register loads from that state. An insert into a
// full table goes straight to the finish state. A new command is taken only while not busy, so
// each command sweeps the slot memory once (a delete that hits twice, a full insert not at all).
// Reset (synchronous, rst_n low) clears valid bits, count and out_valid; out_valid never stalls.
module process_table_keyed_store (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_key_id,
  input  logic [7:0]  in_new_priority,
  input  logic [15:0] in_new_memory,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [7:0]  out_found_priority,
  output logic [15:0] out_found_memory,
  output logic [4:0]  out_entry_count
);

  logic [pte_pkg::DEPTH-1:0] valid_r, valid_nxt;
  pte_pkg::cnt_t             count_r, count_nxt;
  logic                      out_valid_r;
  pte_pkg::status_t          out_status_r;
  logic [7:0]                out_fprio_r;
  logic [15:0]               out_fmem_r;
  pte_pkg::ecount_t          out_count_r;

  logic                      mem_we;
  pte_pkg::idx_t             mem_waddr;
  pte_pkg::slot_t            mem_wdata;
  pte_pkg::idx_t             mem_raddr;
  pte_pkg::slot_t            mem_rdata;
  pte_pkg::upd_t             upd;

  pte_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .cmd          (pte_pkg::cmd_t'(in_cmd)),
    .key_id       (in_key_id),
    .new_priority (in_new_priority),
    .new_memory   (in_new_memory),
    .valid        (valid_r),
    .count        (count_r),
    .busy         (busy),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata),
    .upd          (upd)
  );

  pte_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    if (upd.set_en) begin
      valid_nxt[upd.slot] = 1'b1;
      count_nxt           = count_r + 1'b1;
    end else if (upd.clr_en) begin
      valid_nxt[upd.slot] = 1'b0;
      count_nxt           = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
      out_valid_r <= upd.fin;
    end
  end

  // The result carries the count as it stands after this command's transfer.
  always_ff @(posedge clk) begin
    if (upd.fin) begin
      out_status_r <= upd.status;
      out_fprio_r  <= upd.fprio;
      out_fmem_r   <= upd.fmem;
      out_count_r  <= pte_pkg::ecount_t'(count_nxt);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_priority = out_fprio_r;
  assign out_found_memory   = out_fmem_r;
  assign out_entry_count    = out_count_r;

  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(count_r))
    else $error("live count disagrees with the valid bits");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= pte_pkg::cnt_t'(pte_pkg::DEPTH))
    else $error("live count above table depth");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted command did not start the sequencer");

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while a command is still running");

  a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == pte_pkg::STAT_FULL |->
      count_r == pte_pkg::cnt_t'(pte_pkg::DEPTH))
    else $error("table full reported with free slots");

endmodule

@@ rtl/pte_ram.sv @@
// Slot memory of the process table: one write port, one read port,
// registered read data. Depends on pte_pkg for the record type and depth.
module pte_ram (
  input  logic           clk,
  input  logic           we,
  input  pte_pkg::idx_t  waddr,
  input  pte_pkg::slot_t wdata,
  input  pte_pkg::idx_t  raddr,
  output pte_pkg::slot_t rdata
);

  pte_pkg::slot_t mem_r [pte_pkg::DEPTH];
  pte_pkg::slot_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/pte_seq.sv @@
// Command sequencer: walks every slot of the memory once per command, twice for a delete
// that hits and not at all for an insert into a full table, to find the newest match or
// shift ranks, then commits the record change. Depends on pte_pkg; drives the slot memory in pte_ram.
module pte_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  pte_pkg::cmd_t        cmd,
  input  logic [15:0]          key_id,
  input  logic [7:0]           new_priority,
  input  logic [15:0]          new_memory,
  input  logic [pte_pkg::DEPTH-1:0] valid,
  input  pte_pkg::cnt_t        count,
  output logic                 busy,
  output logic                 mem_we,
  output pte_pkg::idx_t        mem_waddr,
  output pte_pkg::slot_t       mem_wdata,
  output pte_pkg::idx_t        mem_raddr,
  input  pte_pkg::slot_t       mem_rdata,
  output pte_pkg::upd_t        upd
);

  pte_pkg::state_t state_r, state_nxt;
  pte_pkg::cnt_t   cnt_r, cnt_nxt;
  pte_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [15:0]     key_r, key_nxt;
  logic [7:0]      prio_r, prio_nxt;
  logic [15:0]     memsz_r, memsz_nxt;
  logic            full_r, full_nxt;
  logic            hit_r, hit_nxt;
  pte_pkg::idx_t   free_r, free_nxt;
  pte_pkg::idx_t   best_slot_r, best_slot_nxt;
  pte_pkg::slot_t  best_r, best_nxt;

  pte_pkg::idx_t   free_slot;
  pte_pkg::idx_t   proc_slot;
  logic            last;
  logic            proc_live;

  // Lowest-numbered free slot.
  always_comb begin
    free_slot = '0;
    for (int i = pte_pkg::DEPTH - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_slot = pte_pkg::idx_t'(i);
      end
    end
  end

  // Read data in a scan cycle belongs to the slot issued in the previous cycle.
  assign proc_slot = pte_pkg::idx_t'(cnt_r - 1'b1);
  assign last      = (cnt_r == pte_pkg::cnt_t'(pte_pkg::DEPTH));
  assign proc_live = (cnt_r != '0) && valid[proc_slot];
  assign busy      = (state_r != pte_pkg::S_IDLE);
  assign mem_raddr = (cnt_r < pte_pkg::cnt_t'(pte_pkg::DEPTH)) ?
                     pte_pkg::idx_t'(cnt_r) : '0;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    prio_nxt      = prio_r;
    memsz_nxt     = memsz_r;
    full_nxt      = full_r;
    hit_nxt       = hit_r;
    free_nxt      = free_r;
    best_slot_nxt = best_slot_r;
    best_nxt      = best_r;
    mem_we        = 1'b0;
    mem_waddr     = proc_slot;
    mem_wdata     = mem_rdata;
    upd           = '0;

    unique case (state_r)
      pte_pkg::S_IDLE: begin
        if (start) begin
          cmd_nxt   = cmd;
          key_nxt   = key_id;
          prio_nxt  = new_priority;
          memsz_nxt = new_memory;
          cnt_nxt   = '0;
          hit_nxt   = 1'b0;
          free_nxt  = free_slot;
          full_nxt  = (cmd == pte_pkg::CMD_INSERT) &&
                      (count >= pte_pkg::cnt_t'(pte_pkg::DEPTH));
          state_nxt = full_nxt ? pte_pkg::S_FINISH : pte_pkg::S_SCAN;
        end
      end

      pte_pkg::S_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (proc_live) begin
          if (cmd_r == pte_pkg::CMD_INSERT) begin
            mem_we         = 1'b1;
            mem_wdata.rank = pte_pkg::rank_t'(mem_rdata.rank + 1'b1);
          end else if (mem_rdata.id == key_r &&
                       (!hit_r || mem_rdata.rank < best_r.rank)) begin
            hit_nxt       = 1'b1;
            best_slot_nxt = proc_slot;
            best_nxt      = mem_rdata;
          end
        end
        if (last) begin
          cnt_nxt   = '0;
          state_nxt = (cmd_r == pte_pkg::CMD_DELETE && hit_nxt) ?
                      pte_pkg::S_FIX : pte_pkg::S_FINISH;
        end
      end

      // Second pass of a delete: close the gap in the ranks above the victim.
      pte_pkg::S_FIX: begin
        cnt_nxt = cnt_r + 1'b1;
        if (proc_live && mem_rdata.rank > best_r.rank) begin
          mem_we         = 1'b1;
          mem_wdata.rank = pte_pkg::rank_t'(mem_rdata.rank - 1'b1);
        end
        if (last) begin
          state_nxt = pte_pkg::S_FINISH;
        end
      end

      pte_pkg::S_FINISH: begin
        state_nxt = pte_pkg::S_IDLE;
        upd.fin   = 1'b1;
        if (full_r) begin
          upd.status = pte_pkg::STAT_FULL;
        end else if (cmd_r == pte_pkg::CMD_INSERT || hit_r) begin
          upd.status = pte_pkg::STAT_OK;
        end else begin
          upd.status = pte_pkg::STAT_NOT_FOUND;
        end
        unique case (cmd_r)
          pte_pkg::CMD_INSERT: begin
            if (!full_r) begin
              mem_we         = 1'b1;
              mem_waddr      = free_r;
              mem_wdata.id   = key_r;
              mem_wdata.prio = prio_r;
              mem_wdata.mem  = memsz_r;
              mem_wdata.rank = '0;
              upd.set_en     = 1'b1;
              upd.slot       = free_r;
            end
          end
          pte_pkg::CMD_DELETE: begin
            if (hit_r) begin
              upd.clr_en = 1'b1;
              upd.slot   = best_slot_r;
            end
          end
          pte_pkg::CMD_LOOKUP: begin
            if (hit_r) begin
              upd.fprio = best_r.prio;
              upd.fmem  = best_r.mem;
            end
          end
          pte_pkg::CMD_SETPRIO: begin
            if (hit_r) begin
              mem_we         = 1'b1;
              mem_waddr      = best_slot_r;
              mem_wdata      = best_r;
              mem_wdata.prio = prio_r;
            end
          end
          default: begin
          end
        endcase
      end

      default: begin
        state_nxt = pte_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pte_pkg::S_IDLE;
      cnt_r   <= '0;
      full_r  <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      full_r  <= full_nxt;
      hit_r   <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    key_r       <= key_nxt;
    prio_r      <= prio_nxt;
    memsz_r     <= memsz_nxt;
    free_r      <= free_nxt;
    best_slot_r <= best_slot_nxt;
    best_r      <= best_nxt;
  end

endmodule
